@@ rtl/core/vending_change_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Vending change controller assertion macros
// Assertion forms for the core modules (used by vcc_ctrl).
// ----------------------------------------------------------------------------
`ifndef VENDING_CHANGE_CONTROLLER_MACROS_SVH
`define VENDING_CHANGE_CONTROLLER_MACROS_SVH

// Antecedent implies consequent on the next cycle.
`define VCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition holds whenever it is sampled.
`define VCC_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

@@ rtl/core/vcc_pkg.sv @@
// ----------------------------------------------------------------------------
// vcc_pkg
// Types, constants and coin table for the vending change controller.
// ----------------------------------------------------------------------------
package vcc_pkg;

  localparam int NumProducts  = 5;
  localparam int NumCoinKinds = 6;
  localparam int NumPrices    = 5;
  localparam int MaxChange    = 49;

  localparam logic [1:0] ACT_SELECT = 2'd0;
  localparam logic [1:0] ACT_COIN   = 2'd1;
  localparam logic [1:0] ACT_LSTOCK = 2'd2;
  localparam logic [1:0] ACT_LCOIN  = 2'd3;

  localparam logic [3:0] ST_SELECTED = 4'd0;
  localparam logic [3:0] ST_BAD      = 4'd1;
  localparam logic [3:0] ST_SHORT    = 4'd2;
  localparam logic [3:0] ST_BUSY     = 4'd3;
  localparam logic [3:0] ST_REJECT   = 4'd4;
  localparam logic [3:0] ST_NOSALE   = 4'd5;
  localparam logic [3:0] ST_NEED     = 4'd6;
  localparam logic [3:0] ST_CHANGE   = 4'd7;
  localparam logic [3:0] ST_DONE     = 4'd8;
  localparam logic [3:0] ST_FAILED   = 4'd9;
  localparam logic [3:0] ST_LOADED   = 4'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  product;
    logic [7:0]  quantity;
    logic [2:0]  coin_code;
    logic [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  change_coin;
    logic [17:0] amount;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [9:0]  data;
  } cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture input item
    logic mult;       // register price * quantity
    logic exec;       // apply the item, build first result
    logic pay_step;   // one change coin step
    logic pay_final;  // finish payout
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic payout;     // exec found paid >= due
    logic coin_found; // a change coin is available this step
    logic diff_zero;
  } dp_stat_t;

  function automatic logic [5:0] coin_value(input logic [2:0] c);
    case (c)
      3'd0: coin_value = 6'd50;
      3'd1: coin_value = 6'd20;
      3'd2: coin_value = 6'd10;
      3'd3: coin_value = 6'd5;
      3'd4: coin_value = 6'd2;
      3'd5: coin_value = 6'd1;
      default: coin_value = 6'd0;
    endcase
  endfunction

  function automatic logic coin_ok(input logic [2:0] c);
    coin_ok = (32'(c) < NumCoinKinds) && (coin_value(c) != 6'd0);
  endfunction

endpackage

@@ rtl/core/vcc_if.sv @@
// ----------------------------------------------------------------------------
// vcc_if
// Valid/ready channels, each carrying one input, output or config item.
// ----------------------------------------------------------------------------
interface vcc_in_if;
  logic                valid;
  logic                ready;
  vcc_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vcc_out_if;
  logic                valid;
  logic                ready;
  vcc_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vcc_cfg_if;
  logic                valid;
  logic                ready;
  vcc_pkg::cfg_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/vcc_datapath.sv @@
// ----------------------------------------------------------------------------
// vcc_datapath
// Stock, coin counters, sale registers and result formation.
// ----------------------------------------------------------------------------
module vcc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  vcc_pkg::dp_cmd_t    cmd,
  output vcc_pkg::dp_stat_t   stat,
  input  vcc_pkg::in_item_t   item_in,
  input  logic                cfg_we,
  input  vcc_pkg::cfg_item_t  cfg,
  output vcc_pkg::out_item_t  result
);

  logic [9:0]  prices        [vcc_pkg::NumPrices];
  logic [7:0]  product_stock [vcc_pkg::NumProducts];
  logic [15:0] coin_stock    [vcc_pkg::NumCoinKinds];
  logic [15:0] sale_coins    [vcc_pkg::NumCoinKinds];
  logic [17:0] amount_due;
  logic [17:0] amount_paid;
  logic        sale_open;
  logic [5:0]  diff;
  vcc_pkg::in_item_t item;
  logic [17:0] product_mul;

  logic        prod_ok;
  logic [2:0]  pidx;
  logic [17:0] remain;
  logic [17:0] paid_sum;
  logic [2:0]  pick;
  logic        found;
  vcc_pkg::out_item_t exec_res;

  assign prod_ok = 32'(item.product) < vcc_pkg::NumProducts;
  assign pidx    = prod_ok ? item.product : 3'd0;
  assign remain  = (sale_open && amount_paid < amount_due) ? amount_due - amount_paid : 18'd0;
  assign paid_sum = amount_paid + 18'(vcc_pkg::coin_value(item.coin_code));

  // priority pick of largest coin that fits and is in stock
  always_comb begin
    found = 1'b0;
    pick  = 3'd0;
    for (int i = vcc_pkg::NumCoinKinds - 1; i >= 0; i--) begin
      if (vcc_pkg::coin_value(3'(i)) != 6'd0 && diff >= vcc_pkg::coin_value(3'(i)) &&
          coin_stock[i] != 16'd0) begin
        found = 1'b1;
        pick  = 3'(i);
      end
    end
  end

  // result of the executed item (payout results come from the change loop)
  always_comb begin
    exec_res = '{status: vcc_pkg::ST_LOADED, change_coin: 3'd0, amount: 18'd0, last: 1'b1};
    case (item.action)
      vcc_pkg::ACT_SELECT: begin
        if (sale_open) exec_res = '{vcc_pkg::ST_BUSY, 3'd0, remain, 1'b1};
        else if (!prod_ok) exec_res.status = vcc_pkg::ST_BAD;
        else if (item.quantity > product_stock[pidx]) exec_res.status = vcc_pkg::ST_SHORT;
        else exec_res = '{vcc_pkg::ST_SELECTED, 3'd0, product_mul, 1'b1};
      end
      vcc_pkg::ACT_LSTOCK: begin
        if (!prod_ok) exec_res.status = vcc_pkg::ST_BAD;
      end
      vcc_pkg::ACT_LCOIN: begin
        if (!vcc_pkg::coin_ok(item.coin_code))
          exec_res = '{vcc_pkg::ST_REJECT, 3'd0, remain, 1'b1};
      end
      default: begin
        if (!sale_open) exec_res.status = vcc_pkg::ST_NOSALE;
        else if (!vcc_pkg::coin_ok(item.coin_code))
          exec_res = '{vcc_pkg::ST_REJECT, 3'd0, remain, 1'b1};
        else if (paid_sum < amount_due)
          exec_res = '{vcc_pkg::ST_NEED, 3'd0, amount_due - paid_sum, 1'b1};
      end
    endcase
  end

  assign stat.payout     = item.action == vcc_pkg::ACT_COIN && sale_open &&
                           vcc_pkg::coin_ok(item.coin_code) && !(paid_sum < amount_due);
  assign stat.coin_found = found;
  assign stat.diff_zero  = diff == 6'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vcc_pkg::NumPrices; i++) prices[i] <= '0;
      for (int i = 0; i < vcc_pkg::NumProducts; i++) product_stock[i] <= '0;
      for (int i = 0; i < vcc_pkg::NumCoinKinds; i++) begin
        coin_stock[i] <= '0;
        sale_coins[i] <= '0;
      end
      amount_due  <= '0;
      amount_paid <= '0;
      sale_open   <= 1'b0;
      diff        <= '0;
    end else begin
      if (cfg_we && 32'(cfg.index) < vcc_pkg::NumPrices)
        prices[cfg.index[2:0]] <= cfg.data;
      if (cmd.exec) begin
        result <= exec_res;
        case (item.action)
          vcc_pkg::ACT_SELECT: begin
            if (!sale_open && prod_ok && !(item.quantity > product_stock[pidx])) begin
              product_stock[pidx] <= product_stock[pidx] - item.quantity;
              amount_due  <= product_mul;
              amount_paid <= '0;
              sale_open   <= 1'b1;
              for (int i = 0; i < vcc_pkg::NumCoinKinds; i++) sale_coins[i] <= '0;
            end
          end
          vcc_pkg::ACT_LSTOCK: begin
            if (prod_ok)
              product_stock[pidx] <= (item.load_value > 16'd255) ? 8'd255
                                     : item.load_value[7:0];
          end
          vcc_pkg::ACT_LCOIN: begin
            if (vcc_pkg::coin_ok(item.coin_code))
              coin_stock[item.coin_code] <= item.load_value;
          end
          default: begin
            if (sale_open && vcc_pkg::coin_ok(item.coin_code)) begin
              if (sale_coins[item.coin_code] != 16'hFFFF)
                sale_coins[item.coin_code] <= sale_coins[item.coin_code] + 16'd1;
              amount_paid <= paid_sum;
              diff <= 6'(paid_sum - amount_due);
            end
          end
        endcase
      end
      if (cmd.pay_step) begin
        coin_stock[pick] <= coin_stock[pick] - 16'd1;
        diff   <= diff - vcc_pkg::coin_value(pick);
        result <= '{vcc_pkg::ST_CHANGE, pick, 18'(diff - vcc_pkg::coin_value(pick)), 1'b0};
      end
      if (cmd.pay_final) begin
        if (diff == 6'd0) begin
          for (int i = 0; i < vcc_pkg::NumCoinKinds; i++)
            coin_stock[i] <= (17'(coin_stock[i]) + 17'(sale_coins[i]) > 17'h0FFFF) ? 16'hFFFF
                             : coin_stock[i] + sale_coins[i];
          result <= '{vcc_pkg::ST_DONE, 3'd0, 18'd0, 1'b1};
        end else begin
          result <= '{vcc_pkg::ST_FAILED, 3'd0, 18'(diff), 1'b1};
        end
        for (int i = 0; i < vcc_pkg::NumCoinKinds; i++) sale_coins[i] <= '0;
        sale_open   <= 1'b0;
        amount_due  <= '0;
        amount_paid <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item <= item_in;
    if (cmd.mult) product_mul <= 18'(prices[pidx]) * 18'(item.quantity);
  end

endmodule

@@ rtl/core/vcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// vcc_ctrl
// Sequencer: accept, multiply, execute, change payout, result handoff.
// ----------------------------------------------------------------------------
`include "vending_change_controller_macros.svh"

module vcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output vcc_pkg::dp_cmd_t   cmd,
  input  vcc_pkg::dp_stat_t  stat
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MULT  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_SHOW  = 7'b0001000,
    S_STEP  = 7'b0010000,
    S_SHOWC = 7'b0100000,
    S_FINAL = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [5:0]  count, count_next;
  logic        payout, payout_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_SHOW || state == S_SHOWC;

  always_comb begin
    state_next  = state;
    count_next  = count;
    payout_next = payout;
    cmd         = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.latch  = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec    = 1'b1;
        payout_next = stat.payout;
        count_next  = '0;
        state_next  = stat.payout ? S_STEP : S_SHOW;
      end
      S_STEP: begin
        if (!stat.diff_zero && stat.coin_found && 32'(count) < vcc_pkg::MaxChange) begin
          cmd.pay_step = 1'b1;
          count_next   = count + 6'd1;
          state_next   = S_SHOWC;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_SHOWC: if (out_ready) state_next = S_STEP;
      S_FINAL: begin
        cmd.pay_final = 1'b1;
        payout_next   = 1'b0;
        state_next    = S_SHOW;
      end
      S_SHOW: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      payout <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      payout <= payout_next;
    end
  end

  `VCC_ASSERT_ALWAYS(a_onehot, clk, rst, $onehot(state))
  `VCC_ASSERT_NEXT(a_step_shows, clk, rst, cmd.pay_step, state == S_SHOWC)
  `VCC_ASSERT_NEXT(a_final_shows, clk, rst, cmd.pay_final, state == S_SHOW && !payout)
  `VCC_ASSERT_ALWAYS(a_count_cap, clk, rst, 32'(count) <= vcc_pkg::MaxChange)

endmodule

@@ rtl/core/vending_change_controller.sv @@
// From accept: latch, multiply (S_MULT), execute (S_EXEC), then a single result;
// a payout adds an S_STEP/S_SHOWC pass per change coin (up to 49) and S_FINAL.
// One item at a time: a new item is accepted only once the last result is taken.
// Reset (rst, synchronous): prices, stocks, coin counts and sale cleared.
// ----------------------------------------------------------------------------
// vending_change_controller
// Top level: sale sequencer plus stock/coin datapath.
// ----------------------------------------------------------------------------
module vending_change_controller (
  input  logic       clk,
  input  logic       rst,
  vcc_in_if.sink     in_ch,
  vcc_out_if.source  out_ch,
  vcc_cfg_if.sink    cfg_ch
);

  vcc_pkg::dp_cmd_t  cmd;
  vcc_pkg::dp_stat_t stat;

  // Config writes are always taken; the user writes only while idle.
  assign cfg_ch.ready = 1'b1;

  vcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath holds the result register that feeds the output item.
  vcc_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .item_in (in_ch.data),
    .cfg_we  (cfg_ch.valid),
    .cfg     (cfg_ch.data),
    .result  (out_ch.data)
  );

endmodule
